@@ hdl/shll_pkg.sv @@
// Package for the symbol histogram log-likelihood block.
// Holds the transaction structs, mode codes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
package shll_pkg;

    localparam int SYM_BITS  = 16;
    localparam int SUM_BITS  = 48;
    localparam int HITS_BITS = 24;
    localparam int LOG2_FRAC = 30;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_SCORE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] symbol;
        logic [15:0] query_bin;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [47:0]        log_likelihood;
        logic               likelihood_neg_inf;
        logic signed [47:0] log_derivative;
        logic               derivative_neg_inf;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_SC_RD,
        ST_SC_LOG,
        ST_Q_RD,
        ST_H_LOG,
        ST_Q_LOG,
        ST_EMIT
    } t_state;

    // Control between the sequencer and the log unit.
    typedef struct packed {
        logic        start;
        logic [31:0] arg;
    } t_log_req;

    typedef struct packed {
        logic        done;
        logic [47:0] value;
    } t_log_rsp;

endpackage

@@ hdl/shll_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module shll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read before write: a read and a write to the same entry return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ hdl/shll_log.sv @@
// Iterative natural logarithm unit: one squaring step per cycle.
// Depends on shll_pkg.
`timescale 1ns / 1ps
module shll_log #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shll_pkg::t_log_req i_req,
    output shll_pkg::t_log_rsp o_rsp
);
    import shll_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL, L_RND} t_lst;

    t_lst        r_st;
    logic [5:0]  r_cnt;
    logic [32:0] r_m;
    logic [4:0]  r_e;
    logic [29:0] r_frac;
    logic [63:0] r_p;
    logic [47:0] r_val;
    logic        r_done;
    logic [4:0]  w_e;
    logic [65:0] w_sq;
    logic [34:0] w_sh;
    logic [62:0] w_out;

    // Leading-one position of the argument.
    always_comb begin
        w_e = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_req.arg[i]) w_e = 5'(i);
        end
    end

    assign w_sq  = r_m * r_m;
    assign w_sh  = w_sq[65:31];
    assign w_out = r_p[62:0] + (63'd1 << (57 - FRAC_BITS));

    // Squaring sequence, then scale by ln 2 and round.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= r_st == L_RND;
            unique case (r_st)
                L_IDLE: if (i_req.start) begin
                    r_m    <= 33'({i_req.arg, 31'd0} >> w_e);
                    r_e    <= w_e;
                    r_frac <= '0;
                    r_cnt  <= '0;
                    r_st   <= L_SQ;
                end
                L_SQ: begin
                    if (w_sh[32]) begin
                        r_m    <= w_sh[33:1];
                        r_frac <= {r_frac[28:0], 1'b1};
                    end else begin
                        r_m    <= w_sh[32:0];
                        r_frac <= {r_frac[28:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(LOG2_FRAC - 1)) r_st <= L_MUL;
                end
                L_MUL: begin
                    r_p  <= 64'({r_e, r_frac} * LN2_Q28);
                    r_st <= L_RND;
                end
                L_RND: begin
                    r_val <= 48'(w_out >> (58 - FRAC_BITS));
                    r_st  <= L_IDLE;
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;
endmodule

@@ hdl/symbol_histogram_log_likelihood.sv @@
// Top level of the symbol histogram log-likelihood block.
// Depends on shll_pkg, shll_ram and shll_log.
//
// Usage: drive i_item and raise start; a transaction is taken at an edge where
// start is high and busy is low. Count mode reads the bin and writes it back.
// Score mode reads the bin and, if its count is not zero, runs the log unit,
// which takes 30 serial squaring steps. A score item with last set runs up to
// two more logs (hits and query-bin count), then shows one result on o_result
// with strobe high for one cycle; the receiver cannot stall. Clear mode sweeps
// the table. After reset the block sweeps the table to zero with busy high
// before it takes its first transaction.
`timescale 1ns / 1ps
module symbol_histogram_log_likelihood #(
    parameter int NUM_BINS   = 65536,
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  shll_pkg::t_in_item  i_item,
    output logic                strobe,
    output shll_pkg::t_out_item o_result
);
    import shll_pkg::*;

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [HITS_BITS-1:0] HMAX = '1;

    t_state r_st, n_st;
    logic [AW-1:0]         r_addr;
    t_in_item              r_item;
    logic [SUM_BITS-1:0]   r_sum;
    logic                  r_sinf;
    logic [HITS_BITS-1:0]  r_hits;
    logic [SUM_BITS-1:0]   r_lq;
    logic [COUNT_BITS-1:0] r_cq;
    logic                  r_qinr;
    t_out_item             r_res;
    logic                  r_strobe;

    logic                  w_we;
    logic [AW-1:0]         w_addr;
    logic [COUNT_BITS-1:0] w_wdata, w_rdata;
    t_log_req              w_req;
    t_log_rsp              w_rsp;
    logic                  w_sym_in, w_q_in;
    logic [SUM_BITS:0]     w_sum_add;
    logic signed [SUM_BITS+1:0] w_d;

    assign w_sym_in = 32'(r_item.symbol) < 32'(NUM_BINS);
    assign w_q_in   = 32'(r_item.query_bin) < 32'(NUM_BINS);

    shll_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    shll_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_INIT, ST_CLEAR: if (r_addr == AW'(NUM_BINS - 1)) n_st = ST_IDLE;
            ST_IDLE: if (start) begin
                unique case (t_mode'(i_item.mode))
                    MODE_CLEAR: n_st = ST_CLEAR;
                    MODE_COUNT: n_st = ST_CNT_RD;
                    MODE_SCORE: n_st = ST_SC_RD;
                    MODE_NONE:  n_st = ST_IDLE;
                endcase
            end
            ST_CNT_RD: n_st = ST_CNT_WR;
            ST_CNT_WR: n_st = ST_IDLE;
            ST_SC_RD:  n_st = ST_SC_LOG;
            // Score log: skip when count is zero; wait for the log otherwise.
            ST_SC_LOG: if (r_cq == '0 || w_rsp.done)
                n_st = r_item.last ? ST_Q_RD : ST_IDLE;
            // No hits means the derivative is minus infinity, so no logs are needed.
            ST_Q_RD:   n_st = (r_hits == '0) ? ST_EMIT : ST_H_LOG;
            ST_H_LOG:  if (w_rsp.done) n_st = (r_cq == '0) ? ST_EMIT : ST_Q_LOG;
            ST_Q_LOG:  if (w_rsp.done) n_st = ST_EMIT;
            ST_EMIT:   n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    // Outputs to the RAM and the log unit.
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_addr;
        w_wdata = '0;
        w_req   = '0;
        unique case (r_st)
            ST_INIT, ST_CLEAR: w_we = 1'b1;
            ST_IDLE: w_addr = AW'(i_item.symbol);
            ST_CNT_WR: begin
                w_we    = w_sym_in && w_rdata != CMAX;
                w_wdata = w_rdata + 1'b1;
            end
            ST_SC_RD, ST_SC_LOG: w_addr = AW'(r_item.query_bin);
            default: ;
        endcase
        w_req.arg = 32'(r_cq);
        if (r_st == ST_SC_RD) begin
            w_req.start = w_sym_in && w_rdata != '0;
            w_req.arg   = 32'(w_rdata);
        end else if (r_st == ST_Q_RD) begin
            w_req.start = r_hits != '0;
            w_req.arg   = 32'(r_hits);
        end else if (r_st == ST_H_LOG && w_rsp.done) begin
            w_req.start = r_cq != '0;
        end
    end

    assign w_sum_add = {1'b0, r_sum} + {1'b0, w_rsp.value};
    assign w_d = $signed({2'b0, r_sum}) + $signed({2'b0, r_lq})
               - $signed({2'b0, w_rsp.value});

    // Registers and score accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_INIT;
            r_addr   <= '0;
            r_sum    <= '0;
            r_sinf   <= 1'b0;
            r_hits   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_strobe <= r_st == ST_EMIT;
            if (r_st == ST_INIT || r_st == ST_CLEAR) r_addr <= r_addr + 1'b1;
            if (r_st == ST_IDLE) begin
                r_item <= i_item;
                r_addr <= (start && t_mode'(i_item.mode) == MODE_CLEAR)
                    ? '0 : AW'(i_item.symbol);
            end
            if (r_st == ST_SC_RD) begin
                r_cq <= w_sym_in ? w_rdata : '0;
                if (!w_sym_in || w_rdata == '0) r_sinf <= 1'b1;
                if (r_item.symbol == r_item.query_bin && r_hits != HMAX)
                    r_hits <= r_hits + 1'b1;
            end
            if (r_st == ST_SC_LOG && w_rsp.done)
                r_sum <= w_sum_add[SUM_BITS] ? '1 : w_sum_add[SUM_BITS-1:0];
            if (r_st == ST_Q_RD) begin
                r_cq <= w_q_in ? w_rdata : '0;
                r_lq <= '0;
            end
            if (r_st == ST_H_LOG && w_rsp.done) begin
                r_lq <= w_rsp.value;
            end
            if (r_st == ST_Q_LOG && w_rsp.done) begin
                r_res.log_derivative <= (w_d > $signed(50'((64'd1 << 47) - 1)))
                    ? 48'sh7FFF_FFFF_FFFF : w_d[47:0];
            end
            if (r_st == ST_EMIT) begin
                r_res.log_likelihood     <= r_sinf ? '0 : r_sum;
                r_res.likelihood_neg_inf <= r_sinf;
                r_res.derivative_neg_inf <= r_sinf || r_cq == '0 || r_hits == '0;
                if (r_sinf || r_cq == '0 || r_hits == '0) r_res.log_derivative <= '0;
                r_sum    <= '0;
                r_sinf   <= 1'b0;
                r_hits   <= '0;
            end
        end
    end

    assign busy     = r_st != ST_IDLE;
    assign strobe   = r_strobe;
    assign o_result = r_res;

    // The table is only written during a sweep or a count write back.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_st == ST_INIT || r_st == ST_CLEAR || r_st == ST_CNT_WR))
        else $error("unexpected table write");
    // A result follows only the emit state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_st) == ST_EMIT)
        else $error("stray result strobe");
    // A log-likelihood of minus infinity reads zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.likelihood_neg_inf) |-> r_res.log_likelihood == '0)
        else $error("neg inf likelihood not zero");
endmodule
